FILE: hdl/bctc_pkg.sv
package bctc_pkg;

   // Cache geometry and field widths
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int BLOCK_W    = 32;
   localparam int MODE_W     = 2;
   localparam int CMD_W      = 2;

   // Request kinds
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Slot commands on the result channel
   localparam logic [CMD_W-1:0] CMD_NONE      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITEBACK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture the request
      logic compare;     // register the tag match vector
      logic pick;        // choose hit, free or victim slot
      logic evict;       // drop slot 0, write it back if dirty
      logic xfer;        // issue the disk read or write through
      logic flush_step;  // visit one slot of the flush scan
      logic finish;      // issue the last result
   } ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              hit_any;
      logic              free_any;
      logic              wb_needed;
      logic              flush_hit;
      logic              flush_last;
      logic              out_free;
   } stat_type;

endpackage

FILE: hdl/bctc_ctrl.sv
module bctc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bctc_pkg::stat_type stat,
   output bctc_pkg::ctl_type  ctl
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_PICK  = 3'd2;
   localparam logic [2:0] ST_EVICT = 3'd3;
   localparam logic [2:0] ST_XFER  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;
   localparam logic [2:0] ST_FINAL = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence one request through lookup, slot commands and the last result
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            ctl.compare = 1'b1;
            unique case (stat.mode) inside
               bctc_pkg::MODE_READ, bctc_pkg::MODE_WRITE: state_in = ST_PICK;
               bctc_pkg::MODE_FLUSH:                      state_in = ST_FLUSH;
               default:                                   state_in = ST_FINAL;
            endcase
         end
         ST_PICK: begin
            ctl.pick = 1'b1;
            if (!stat.hit_any && !stat.free_any) begin
               state_in = ST_EVICT;
            end else if (stat.hit_any && stat.mode == bctc_pkg::MODE_READ) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_XFER;
            end
         end
         ST_EVICT: begin
            if (!stat.wb_needed || stat.out_free) begin
               ctl.evict = 1'b1;
               state_in  = ST_XFER;
            end
         end
         ST_XFER: begin
            if (stat.out_free) begin
               ctl.xfer = 1'b1;
               state_in = ST_FINAL;
            end
         end
         ST_FLUSH: begin
            if (!stat.flush_hit || stat.out_free) begin
               ctl.flush_step = 1'b1;
               if (stat.flush_last) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (stat.out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/bctc_datapath.sv
module bctc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bctc_pkg::ctl_type                   ctl,
   output bctc_pkg::stat_type                  stat,
   input  logic [bctc_pkg::MODE_W-1:0]         req_mode,
   input  logic [bctc_pkg::BLOCK_W-1:0]        req_block_number,
   input  logic                                req_disk_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bctc_pkg::CMD_W-1:0]          rsp_command,
   output logic [bctc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [bctc_pkg::BLOCK_W-1:0]        rsp_disk_block,
   output logic                                rsp_hit,
   output logic                                rsp_status,
   output logic [bctc_pkg::COUNT_W-1:0]        rsp_valid_count,
   output logic [bctc_pkg::COUNT_W-1:0]        rsp_dirty_count,
   output logic                                rsp_last
);

   localparam int N  = bctc_pkg::SLOT_COUNT;
   localparam int SW = bctc_pkg::SLOT_W;
   localparam int CW = bctc_pkg::COUNT_W;
   localparam int BW = bctc_pkg::BLOCK_W;

   // Request registers
   logic [bctc_pkg::MODE_W-1:0] mode_ff;
   logic [BW-1:0]               blk_ff;
   logic                        ok_ff;
   logic [N-1:0]                match_ff;
   logic                        hit_ff, hit_in;
   logic                        fail_ff, fail_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic [SW-1:0]               idx_ff, idx_in;

   // Slot state
   logic [BW-1:0] tags_ff [N];
   logic [N-1:0]  valid_ff, valid_in;
   logic [N-1:0]  dirty_ff, dirty_in;
   logic          tag_we;
   logic [SW-1:0] tag_waddr;

   // Result register
   logic                        out_valid_ff, out_valid_in;
   logic [bctc_pkg::CMD_W-1:0]  out_cmd_ff, out_cmd_in;
   logic [SW-1:0]               out_slot_ff, out_slot_in;
   logic [BW-1:0]               out_blk_ff, out_blk_in;
   logic                        out_hit_ff, out_hit_in;
   logic                        out_status_ff, out_status_in;
   logic [CW-1:0]               out_vc_ff, out_vc_in;
   logic [CW-1:0]               out_dc_ff, out_dc_in;
   logic                        out_last_ff, out_last_in;
   logic                        emit;

   // Lookup helpers
   logic [N-1:0]  match_now;
   logic [SW-1:0] hit_idx, free_idx;
   logic [CW-1:0] vcount, dcount;
   logic          out_free;

   // Compare every valid tag against the requested block
   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_now[i] = valid_ff[i] && (tags_ff[i] == blk_ff);
      end
   end

   // Find the lowest matching and the lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = SW'(i);
         if (!valid_ff[i]) free_idx = SW'(i);
      end
   end

   // Count valid and valid dirty slots
   always_comb begin
      vcount = '0;
      dcount = '0;
      for (int i = 0; i < N; i++) begin
         vcount = vcount + CW'(valid_ff[i]);
         dcount = dcount + CW'(valid_ff[i] & dirty_ff[i]);
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      stat.mode       = mode_ff;
      stat.hit_any    = |match_ff;
      stat.free_any   = ~&valid_ff;
      stat.wb_needed  = dirty_ff[0];
      stat.flush_hit  = valid_ff[idx_ff] && dirty_ff[idx_ff];
      stat.flush_last = (idx_ff == SW'(N - 1));
      stat.out_free   = out_free;
   end

   // Next slot state, request state and result
   always_comb begin
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      hit_in        = hit_ff;
      fail_in       = fail_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      tag_we        = 1'b0;
      tag_waddr     = slot_ff;
      emit          = 1'b0;
      out_cmd_in    = out_cmd_ff;
      out_slot_in   = out_slot_ff;
      out_blk_in    = out_blk_ff;
      out_hit_in    = 1'b0;
      out_status_in = 1'b0;
      out_vc_in     = '0;
      out_dc_in     = '0;
      out_last_in   = 1'b0;

      if (ctl.load) begin
         hit_in  = 1'b0;
         fail_in = 1'b0;
         slot_in = '0;
         idx_in  = '0;
      end

      if (ctl.pick) begin
         hit_in = |match_ff;
         if (|match_ff) begin
            slot_in = hit_idx;
         end else if (~&valid_ff) begin
            slot_in = free_idx;
         end else begin
            slot_in = '0;
         end
      end

      if (ctl.evict) begin
         if (dirty_ff[0]) begin
            emit        = 1'b1;
            out_cmd_in  = bctc_pkg::CMD_WRITEBACK;
            out_slot_in = '0;
            out_blk_in  = tags_ff[0];
         end
         valid_in[0] = 1'b0;
         dirty_in[0] = 1'b0;
      end

      if (ctl.xfer) begin
         emit        = 1'b1;
         out_slot_in = slot_ff;
         out_blk_in  = blk_ff;
         if (mode_ff == bctc_pkg::MODE_WRITE) begin
            out_cmd_in        = bctc_pkg::CMD_WRITE;
            tag_we            = 1'b1;
            valid_in[slot_ff] = 1'b1;
            dirty_in[slot_ff] = !ok_ff;
            fail_in           = !ok_ff;
         end else begin
            out_cmd_in = bctc_pkg::CMD_READ;
            if (ok_ff) begin
               tag_we            = 1'b1;
               valid_in[slot_ff] = 1'b1;
               dirty_in[slot_ff] = 1'b0;
            end else begin
               fail_in = 1'b1;
            end
         end
      end

      if (ctl.flush_step) begin
         if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
            emit             = 1'b1;
            out_cmd_in       = bctc_pkg::CMD_WRITEBACK;
            out_slot_in      = idx_ff;
            out_blk_in       = tags_ff[idx_ff];
            dirty_in[idx_ff] = 1'b0;
         end
         idx_in = idx_ff + SW'(1);
      end

      if (ctl.finish) begin
         emit          = 1'b1;
         out_cmd_in    = bctc_pkg::CMD_NONE;
         out_slot_in   = slot_ff;
         out_blk_in    = (mode_ff == bctc_pkg::MODE_READ || mode_ff == bctc_pkg::MODE_WRITE)
                         ? blk_ff : '0;
         out_hit_in    = hit_ff;
         out_status_in = fail_ff;
         out_vc_in     = vcount;
         out_dc_in     = dcount;
         out_last_in   = 1'b1;
      end

      // Hold the result until its transfer, then drop valid
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mode_ff <= req_mode;
         blk_ff  <= req_block_number;
         ok_ff   <= req_disk_ok;
      end
      if (ctl.compare) begin
         match_ff <= match_now;
      end
      if (tag_we) begin
         tags_ff[tag_waddr] <= blk_ff;
      end
      hit_ff  <= hit_in;
      fail_ff <= fail_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      if (emit) begin
         out_cmd_ff    <= out_cmd_in;
         out_slot_ff   <= out_slot_in;
         out_blk_ff    <= out_blk_in;
         out_hit_ff    <= out_hit_in;
         out_status_ff <= out_status_in;
         out_vc_ff     <= out_vc_in;
         out_dc_ff     <= out_dc_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_command     = out_cmd_ff;
   assign rsp_slot        = out_slot_ff;
   assign rsp_disk_block  = out_blk_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_valid_count = out_vc_ff;
   assign rsp_dirty_count = out_dc_ff;
   assign rsp_last        = out_last_ff;

endmodule

FILE: hdl/block_cache_tag_controller_unit.sv
// Tag and state engine of a 16-slot fully associative write-through block cache.
// Request channel (req_): mode (read, write, flush), block number and the
// outcome of the disk transfer. Result channel (rsp_): zero or more slot
// commands (write back, read into slot, write through), then one result with
// last set that carries hit, status and the valid and dirty slot counts.
// One request is worked on at a time; req_ready is high only while idle.
// An unused mode and a read hit issue only the last result; a miss or write
// that finds a slot first issues its read or write command, and one that
// finds none first evicts slot 0. A flush visits all 16 slots, one per cycle
// while no write back waits on the result register. The next request is
// taken the cycle after the last result is issued.
// The tag compare is registered before the slot is chosen. Every result
// waits in one output register; when the receiver stalls, a step that issues
// a result holds until that register is free, so a stall delays the
// remaining steps by up to its own length.
// Reset clears all valid and dirty bits and the result valid flag; tags hold
// no value until a slot is filled and are read only while the slot is valid.
module block_cache_tag_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bctc_pkg::MODE_W-1:0]         req_mode,
   input  logic [bctc_pkg::BLOCK_W-1:0]        req_block_number,
   input  logic                                req_disk_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bctc_pkg::CMD_W-1:0]          rsp_command,
   output logic [bctc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [bctc_pkg::BLOCK_W-1:0]        rsp_disk_block,
   output logic                                rsp_hit,
   output logic                                rsp_status,
   output logic [bctc_pkg::COUNT_W-1:0]        rsp_valid_count,
   output logic [bctc_pkg::COUNT_W-1:0]        rsp_dirty_count,
   output logic                                rsp_last
);

   bctc_pkg::ctl_type  ctl;
   bctc_pkg::stat_type stat;

   bctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   bctc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_block_number (req_block_number),
      .req_disk_ok      (req_disk_ok),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command      (rsp_command),
      .rsp_slot         (rsp_slot),
      .rsp_disk_block   (rsp_disk_block),
      .rsp_hit          (rsp_hit),
      .rsp_status       (rsp_status),
      .rsp_valid_count  (rsp_valid_count),
      .rsp_dirty_count  (rsp_dirty_count),
      .rsp_last         (rsp_last)
   );

endmodule
